/* rtl/core/sopr_pkg.sv */
// Package for the stream offset pointer resolver.
// Holds request kinds, status codes, payload structs and the resolve bias.
// No dependencies.
package sopr_pkg;

    // Number of streams, fixed by the three bit stream id of the request word.
    localparam int STREAM_COUNT = 8;

    typedef enum logic [2:0] {
        K_ADVANCE = 3'd0,
        K_ALIGN   = 3'd1,
        K_PUSH    = 3'd2,
        K_POP     = 3'd3,
        K_STORE   = 3'd4,
        K_RESOLVE = 3'd5,
        K_CLEAR   = 3'd6,
        K_NOP     = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PAST_END  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_STACK     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    localparam logic [31:0] RESOLVE_BIAS = 32'h0000_0030;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] amount;
        logic [2:0]  stream_id;
        logic [31:0] request_offset;
    } t_in_word;

    typedef struct packed {
        logic [31:0] file_position;
        logic [31:0] resolved_position;
        logic [2:0]  status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // Result of the table scan handed back to the control.
    typedef struct packed {
        logic        done;
        logic        found;
        logic [31:0] position;
    } t_scan_res;

endpackage

/* rtl/core/sopr_table.sv */
// Pointer entry table with its sequential two pass scanner.
// Depends on sopr_pkg. One synchronous memory, one read per cycle.
module sopr_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [2:0]                i_wr_stream,
    input  logic [31:0]               i_wr_offset,
    input  logic [31:0]               i_wr_fpos,
    input  logic [31:0]               i_wr_size,
    input  logic                      i_start,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_count,
    input  logic [2:0]                i_stream,
    input  logic [31:0]               i_req,
    output sopr_pkg::t_scan_res       o_res
);
    import sopr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [98:0] mem [TABLE_DEPTH];
    logic [98:0] r_rd;
    logic        r_busy, n_busy;
    logic        r_pass, n_pass;     // 0 exact pass, 1 range pass
    logic [CW-1:0] r_idx, n_idx;     // address issued
    logic        r_vld, n_vld;       // r_rd holds a valid entry
    logic [AW-1:0] rd_addr;
    t_scan_res   n_res;

    assign rd_addr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_wr_addr] <= {i_wr_stream, i_wr_offset, i_wr_fpos, i_wr_size};
        end
        r_rd <= mem[rd_addr];
    end

    logic [2:0]  e_stream;
    logic [31:0] e_off, e_fpos, e_size, diff;
    assign e_stream = r_rd[98:96];
    assign e_off    = r_rd[95:64];
    assign e_fpos   = r_rd[63:32];
    assign e_size   = r_rd[31:0];
    assign diff     = i_req - e_off;

    always_comb begin
        n_busy = r_busy;
        n_pass = r_pass;
        n_idx  = r_idx;
        n_vld  = 1'b0;
        n_res  = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_pass = 1'b0;
            n_idx  = '0;
        end else if (r_busy) begin
            if (r_vld && !r_pass && e_stream == i_stream && e_off == i_req) begin
                n_res  = '{done: 1'b1, found: 1'b1, position: e_fpos};
                n_busy = 1'b0;
            end else if (r_vld && r_pass && e_stream == i_stream && e_off < i_req
                         && diff < e_size) begin
                n_res  = '{done: 1'b1, found: 1'b1,
                           position: e_fpos + diff - RESOLVE_BIAS};
                n_busy = 1'b0;
            end else if (r_idx < i_count) begin
                n_idx = r_idx + 1'b1;
                n_vld = 1'b1;
            end else if (!r_pass) begin
                n_pass = 1'b1;
                n_idx  = '0;
            end else begin
                n_res  = '{done: 1'b1, found: 1'b0, position: 32'd0};
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_idx  <= '0;
            r_vld  <= 1'b0;
            o_res  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pass <= n_pass;
            r_idx  <= n_idx;
            r_vld  <= n_vld;
            o_res  <= n_res;
        end
    end
endmodule

/* rtl/core/stream_offset_pointer_resolver.sv */
// Top level of the stream offset pointer resolver.
// Depends on sopr_pkg and sopr_table.
//
// Usage: one request word enters on i_in_* and produces exactly one result
// word on o_out_*. Both channels use valid/ready. The single configuration
// register, the buffer size, is written through i_cfg_valid/o_cfg_ready;
// the user writes it only while the block is idle; the block does not check.
// Advance, align, push, pop, store and clear pass from acceptance through
// EXEC, which reads the stack top and its offset, then computes and writes
// back, and DONE, which moves the result into the output register.
// A resolve scans the entry table one entry per cycle, first for an exact
// match and then for a range match.
// One request executes at a time; the next request is accepted as soon as
// the previous result has moved into the output register, even if it is not
// yet taken.
// Reset (synchronous, active low) clears the read position, the stack and
// table counts and the buffer size. Stream offsets are cleared through a
// valid bit per stream kept in flip-flops. The stack and table memories
// hold no reset. When the receiver stalls, the result word is held in the
// output register; one more request may still be accepted and executed,
// and its result then waits in the block, which holds off the input.
module stream_offset_pointer_resolver #(
    parameter int STACK_DEPTH = 16,
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sopr_pkg::t_in_word i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sopr_pkg::t_out_word o_out_data
);
    import sopr_pkg::*;

    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int TCW = $clog2(TABLE_DEPTH + 1);

    // Stream offset memory; an entry whose valid bit is clear reads as zero.
    logic [31:0] offs_mem [STREAM_COUNT];
    logic [STREAM_COUNT-1:0] r_offs_vld;
    logic [31:0] r_offs_rd;
    logic [2:0]  offs_raddr;
    logic        offs_we;
    logic [31:0] offs_wdata;

    // Stack memory, read ahead at the top slot.
    logic [2:0]  stack_mem [STACK_DEPTH];
    logic [2:0]  r_top_rd;

    logic [31:0]  r_buf_size;
    logic [31:0]  r_pos, n_pos;
    logic [SCW-1:0] r_sp, n_sp;
    logic [TCW-1:0] r_ecnt, n_ecnt;
    t_state       r_state, n_state;
    t_in_word     r_req, n_req;
    logic         r_out_valid, n_out_valid;
    t_out_word    r_out, n_out;
    t_out_word    r_res, n_res;   // finished result waiting for the output register
    logic         r_top_vld;  // latch stage: r_top_rd/r_offs_rd valid
    logic         scan_start;
    t_scan_res    scan_res;
    logic [2:0]   top_sid;
    logic [31:0]  top_off;
    logic         tbl_we;
    logic [SAW-1:0] top_addr;
    logic [32:0]  adv_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign top_addr = SAW'(r_sp - 1'b1);
    assign top_sid  = r_top_rd;
    assign top_off  = r_offs_vld[top_sid] ? r_offs_rd : 32'd0;
    assign offs_raddr = top_sid;
    assign adv_sum  = {1'b0, r_pos} + {2'b0, r_req.amount};

    always_ff @(posedge i_clk) begin
        r_top_rd <= stack_mem[top_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && t_kind'(r_req.kind) == K_PUSH
            && r_sp < SCW'(STACK_DEPTH) && 32'(r_req.stream_id) < STREAM_COUNT) begin
            stack_mem[r_sp[SAW-1:0]] <= r_req.stream_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offs_rd <= offs_mem[offs_raddr];
        if (offs_we) begin
            offs_mem[top_sid] <= offs_wdata;
        end
    end

    sopr_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_we),
        .i_wr_addr   (r_ecnt[TAW-1:0]),
        .i_wr_stream (r_top_rd),
        .i_wr_offset (top_off),
        .i_wr_fpos   (r_pos),
        .i_wr_size   ({1'b0, r_req.amount}),
        .i_start     (scan_start),
        .i_count     (r_ecnt),
        .i_stream    (r_req.stream_id),
        .i_req       (r_req.request_offset),
        .o_res       (scan_res)
    );

    // IDLE accepts, EXEC first waits for the top slot and offset reads
    // (r_top_vld), then executes; SCAN waits on the table scanner. DONE hands
    // the result to the output register once that register is free.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_pos       = r_pos;
        n_sp        = r_sp;
        n_ecnt      = r_ecnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_res       = r_res;
        offs_we     = 1'b0;
        offs_wdata  = 32'd0;
        tbl_we      = 1'b0;
        scan_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_top_vld) begin
                    n_res.file_position     = r_pos;
                    n_res.resolved_position = 32'd0;
                    n_res.status            = ST_OK;
                    n_state                 = S_DONE;
                    unique case (t_kind'(r_req.kind))
                        K_ADVANCE: begin
                            if (adv_sum > {1'b0, r_buf_size}) begin
                                n_res.status = ST_PAST_END;
                            end else begin
                                n_pos = adv_sum[31:0];
                                n_res.file_position = adv_sum[31:0];
                                if (r_sp != '0) begin
                                    offs_we    = 1'b1;
                                    offs_wdata = top_off + {1'b0, r_req.amount};
                                end
                            end
                        end
                        K_ALIGN: begin
                            if (r_sp == '0) begin
                                n_res.status = ST_STACK;
                            end else begin
                                offs_we    = 1'b1;
                                offs_wdata = ~{1'b0, r_req.amount}
                                             & ({1'b0, r_req.amount} + top_off);
                            end
                        end
                        K_PUSH: begin
                            if (r_sp >= SCW'(STACK_DEPTH)
                                || 32'(r_req.stream_id) >= STREAM_COUNT) begin
                                n_res.status = ST_STACK;
                            end else begin
                                n_sp = r_sp + 1'b1;
                            end
                        end
                        K_POP: begin
                            if (r_sp == '0) n_res.status = ST_STACK;
                            else n_sp = r_sp - 1'b1;
                        end
                        K_STORE: begin
                            if (r_sp == '0) begin
                                n_res.status = ST_STACK;
                            end else if (r_ecnt >= TCW'(TABLE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                tbl_we = 1'b1;
                                n_ecnt = r_ecnt + 1'b1;
                            end
                        end
                        K_RESOLVE: begin
                            scan_start = 1'b1;
                            n_state    = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_res.file_position     = r_pos;
                    n_res.resolved_position = scan_res.position;
                    n_res.status            = scan_res.found ? ST_OK : ST_NOT_FOUND;
                    n_state                 = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
        r_res <= n_res;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 32'd0;
            r_sp        <= '0;
            r_ecnt      <= '0;
            r_out_valid <= 1'b0;
            r_buf_size  <= 32'd0;
            r_offs_vld  <= '0;
            r_top_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_sp        <= n_sp;
            r_ecnt      <= n_ecnt;
            r_out_valid <= n_out_valid;
            r_top_vld   <= (n_state == S_EXEC) && (r_state == S_EXEC);
            if (i_cfg_valid) r_buf_size <= i_cfg_data;
            if (r_state == S_EXEC && r_top_vld && t_kind'(r_req.kind) == K_CLEAR) begin
                r_offs_vld <= '0;
            end else if (offs_we) begin
                r_offs_vld[top_sid] <= 1'b1;
            end
        end
    end
endmodule
